// ----- design/sorted_key_table_top_assert.svh -----
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SKT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/skt_pkg.sv -----
package skt_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_MOV,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_INDEX,
        RD_PREV,
        RD_PREV2,
        RD_MID,
        RD_MID_NEXT,
        RD_NEXT2
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_FULL,
        RES_MISS,
        RES_DONE_IDX,
        RES_FOUND,
        RES_HIT,
        RES_CLEAR
    } res_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_key;
        logic    idx_dec;
        logic    idx_inc;
        logic    idx_set_mid;
        logic    mid_load;
        logic    search_step;
        logic    count_inc;
        logic    count_dec;
        logic    count_clr;
        res_t    res;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic gt;
        logic eq;
        logic idx_is_one;
        logic search_over;
        logic del_more;
        logic move_more;
    } stat_t;

endpackage

// ----- design/skt_dp.sv -----
module skt_dp #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [skt_pkg::REQ_W-1:0]     req_type,
    input  logic [skt_pkg::KEY_W-1:0]     key,
    input  skt_pkg::cmd_t                 cmd,
    output skt_pkg::stat_t                stat,
    output logic [skt_pkg::STATUS_W-1:0]  status,
    output logic [skt_pkg::FOUND_W-1:0]   found_key,
    output logic [skt_pkg::POS_W-1:0]     position,
    output logic [skt_pkg::COUNT_W-1:0]   count,
    output logic                          full_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    skt_pkg::req_t        req_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        index_reg;
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [AW-1:0]        mid_reg;
    logic [KEY_WIDTH-1:0] rdata_reg;
    skt_pkg::status_t     status_reg;
    logic [KEY_WIDTH-1:0] found_reg;
    logic [AW-1:0]        pos_reg;

    logic [KEY_WIDTH+skt_pkg::KEY_W-1:0]     key_wide;
    logic [KEY_WIDTH-1:0]                    key_in;
    logic [CW-1:0]                           span;
    logic [CW-1:0]                           mid_full;
    logic [AW-1:0]                           mid_c;
    logic                                    lt;
    logic [CW-1:0]                           lo_next;
    logic [CW-1:0]                           hi_next;
    logic [AW-1:0]                           raddr;
    logic [KEY_WIDTH-1:0]                    wdata;
    logic [KEY_WIDTH+skt_pkg::FOUND_W-1:0]   found_wide;
    logic [AW+skt_pkg::POS_W-1:0]            pos_wide;
    logic [CW+skt_pkg::COUNT_W-1:0]          count_wide;

    assign key_wide = {{KEY_WIDTH{1'b0}}, key};
    assign key_in   = key_wide[KEY_WIDTH-1:0];

    assign span     = hi_reg - lo_reg - CW'(1);
    assign mid_full = lo_reg + (span >> 1);
    assign mid_c    = mid_full[AW-1:0];

    assign lt      = rdata_reg < key_reg;
    assign lo_next = lt ? (CW'(mid_reg) + CW'(1)) : lo_reg;
    assign hi_next = lt ? hi_reg : CW'(mid_reg);

    assign stat.req         = req_reg;
    assign stat.full        = count_reg == CW'(DEPTH);
    assign stat.empty       = count_reg == '0;
    assign stat.gt          = rdata_reg > key_reg;
    assign stat.eq          = rdata_reg == key_reg;
    assign stat.idx_is_one  = index_reg == AW'(1);
    assign stat.search_over = lo_next >= hi_next;
    assign stat.del_more    = (CW'(mid_reg) + CW'(1)) < count_reg;
    assign stat.move_more   = ((CW + 1)'(index_reg) + (CW + 1)'(2)) < (CW + 1)'(count_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            skt_pkg::RD_PREV:     raddr = index_reg - AW'(1);
            skt_pkg::RD_PREV2:    raddr = index_reg - AW'(2);
            skt_pkg::RD_MID:      raddr = mid_c;
            skt_pkg::RD_MID_NEXT: raddr = mid_reg + AW'(1);
            skt_pkg::RD_NEXT2:    raddr = index_reg + AW'(2);
            default:              raddr = index_reg;
        endcase
    end

    assign wdata = cmd.wr_key ? key_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[index_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_clr)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= skt_pkg::req_t'(req_type);
            key_reg   <= key_in;
            index_reg <= count_reg[AW-1:0];
            lo_reg    <= '0;
            hi_reg    <= count_reg;
        end
        else
        begin
            if (cmd.idx_set_mid)
            begin
                index_reg <= mid_reg;
            end
            else if (cmd.idx_dec)
            begin
                index_reg <= index_reg - AW'(1);
            end
            else if (cmd.idx_inc)
            begin
                index_reg <= index_reg + AW'(1);
            end
            if (cmd.search_step)
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
        end
        if (cmd.mid_load)
        begin
            mid_reg <= mid_c;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.res)
            skt_pkg::RES_FULL:
            begin
                status_reg <= skt_pkg::ST_FULL;
                found_reg  <= '0;
                pos_reg    <= '0;
            end
            skt_pkg::RES_MISS:
            begin
                status_reg <= skt_pkg::ST_NOT_FOUND;
                found_reg  <= '0;
                pos_reg    <= '0;
            end
            skt_pkg::RES_DONE_IDX:
            begin
                status_reg <= skt_pkg::ST_OK;
                found_reg  <= '0;
                pos_reg    <= index_reg;
            end
            skt_pkg::RES_FOUND:
            begin
                status_reg <= skt_pkg::ST_OK;
                found_reg  <= rdata_reg;
                pos_reg    <= mid_reg;
            end
            skt_pkg::RES_HIT:
            begin
                status_reg <= skt_pkg::ST_OK;
                found_reg  <= '0;
                pos_reg    <= mid_reg;
            end
            skt_pkg::RES_CLEAR:
            begin
                status_reg <= skt_pkg::ST_OK;
                found_reg  <= '0;
                pos_reg    <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign found_wide = {{skt_pkg::FOUND_W{1'b0}}, found_reg};
    assign pos_wide   = {{skt_pkg::POS_W{1'b0}}, pos_reg};
    assign count_wide = {{skt_pkg::COUNT_W{1'b0}}, count_reg};

    assign status    = status_reg;
    assign found_key = found_wide[skt_pkg::FOUND_W-1:0];
    assign position  = pos_wide[skt_pkg::POS_W-1:0];
    assign count     = count_wide[skt_pkg::COUNT_W-1:0];
    assign full_res  = stat.full;

endmodule

// ----- design/skt_ctrl.sv -----
`include "sorted_key_table_top_assert.svh"

module skt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  skt_pkg::stat_t stat,
    output skt_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = skt_pkg::S_DISPATCH;
                end
            end
            skt_pkg::S_DISPATCH:
            begin
                if (stat.req == skt_pkg::REQ_INSERT)
                begin
                    if (stat.full)
                    begin
                        state_next = skt_pkg::S_RESP;
                    end
                    else if (stat.empty)
                    begin
                        state_next = skt_pkg::S_INS_PUT;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_INS_CMP;
                    end
                end
                else if (stat.req inside {skt_pkg::REQ_LOOKUP, skt_pkg::REQ_DELETE})
                begin
                    state_next = stat.empty ? skt_pkg::S_RESP : skt_pkg::S_SRCH_RD;
                end
                else
                begin
                    state_next = skt_pkg::S_RESP;
                end
            end
            skt_pkg::S_INS_CMP:
            begin
                if (!stat.gt)
                begin
                    state_next = skt_pkg::S_RESP;
                end
                else if (stat.idx_is_one)
                begin
                    state_next = skt_pkg::S_INS_PUT;
                end
            end
            skt_pkg::S_INS_PUT:
            begin
                state_next = skt_pkg::S_RESP;
            end
            skt_pkg::S_SRCH_RD:
            begin
                state_next = skt_pkg::S_SRCH_CMP;
            end
            skt_pkg::S_SRCH_CMP:
            begin
                if (stat.eq)
                begin
                    if (stat.req == skt_pkg::REQ_DELETE && stat.del_more)
                    begin
                        state_next = skt_pkg::S_DEL_MOV;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_RESP;
                    end
                end
                else
                begin
                    state_next = stat.search_over ? skt_pkg::S_RESP : skt_pkg::S_SRCH_RD;
                end
            end
            skt_pkg::S_DEL_MOV:
            begin
                if (!stat.move_more)
                begin
                    state_next = skt_pkg::S_RESP;
                end
            end
            skt_pkg::S_RESP:
            begin
                state_next = skt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = skt_pkg::RD_INDEX;
        cmd.res    = skt_pkg::RES_NONE;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            skt_pkg::S_DISPATCH:
            begin
                if (stat.req == skt_pkg::REQ_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.res = skt_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.rd_sel = skt_pkg::RD_PREV;
                    end
                end
                else if (stat.req inside {skt_pkg::REQ_LOOKUP, skt_pkg::REQ_DELETE})
                begin
                    if (stat.empty)
                    begin
                        cmd.res = skt_pkg::RES_MISS;
                    end
                end
                else
                begin
                    cmd.count_clr = 1'b1;
                    cmd.res       = skt_pkg::RES_CLEAR;
                end
            end
            skt_pkg::S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.gt)
                begin
                    cmd.idx_dec = 1'b1;
                    cmd.rd_sel  = skt_pkg::RD_PREV2;
                end
                else
                begin
                    cmd.wr_key    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.res       = skt_pkg::RES_DONE_IDX;
                end
            end
            skt_pkg::S_INS_PUT:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_key    = 1'b1;
                cmd.count_inc = 1'b1;
                cmd.res       = skt_pkg::RES_DONE_IDX;
            end
            skt_pkg::S_SRCH_RD:
            begin
                cmd.rd_sel   = skt_pkg::RD_MID;
                cmd.mid_load = 1'b1;
            end
            skt_pkg::S_SRCH_CMP:
            begin
                if (stat.eq)
                begin
                    if (stat.req == skt_pkg::REQ_DELETE)
                    begin
                        cmd.res = skt_pkg::RES_HIT;
                        if (stat.del_more)
                        begin
                            cmd.idx_set_mid = 1'b1;
                            cmd.rd_sel      = skt_pkg::RD_MID_NEXT;
                        end
                        else
                        begin
                            cmd.count_dec = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.res = skt_pkg::RES_FOUND;
                    end
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    if (stat.search_over)
                    begin
                        cmd.res = skt_pkg::RES_MISS;
                    end
                end
            end
            skt_pkg::S_DEL_MOV:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                cmd.rd_sel  = skt_pkg::RD_NEXT2;
                if (!stat.move_more)
                begin
                    cmd.count_dec = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != skt_pkg::S_IDLE;
    assign done = state_reg == skt_pkg::S_RESP;

    `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `SKT_ASSERT_NEXT(a_done_release, done, !busy && !done, "result strobe not followed by idle")
    `SKT_ASSERT_IMPLY(a_grow_not_full, cmd.count_inc, !stat.full, "insert grew a full table")
    `SKT_ASSERT_IMPLY(a_shrink_not_empty, cmd.count_dec, !stat.empty, "delete shrank an empty table")

endmodule

// ----- design/sorted_key_table_top.sv -----
// Channel   Ports                                        Handshake
// request   req_type, key                                start high, busy low
// result    status, found_key, position, count, full_res done strobe, one cycle
//
// Keys live in a single-port-read memory with registered read data, one read and one write
// per cycle; that port sets the timing. Clear, refused insert and lookup or delete on an
// empty table go straight to the result; insert moves each larger key up one slot, lookup
// reads and compares once per search probe, delete also moves each later key down a slot.
// Reset clears the controller and the count only; the key memory needs no clearing pass.
// Busy stays high from the transfer until the strobe cycle; the receiver cannot stall.
module sorted_key_table_top #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [skt_pkg::REQ_W-1:0]     req_type,
    input  logic [skt_pkg::KEY_W-1:0]     key,
    output logic                          done,
    output logic [skt_pkg::STATUS_W-1:0]  status,
    output logic [skt_pkg::FOUND_W-1:0]   found_key,
    output logic [skt_pkg::POS_W-1:0]     position,
    output logic [skt_pkg::COUNT_W-1:0]   count,
    output logic                          full_res
);

    skt_pkg::cmd_t  cmd;
    skt_pkg::stat_t stat;

    skt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    skt_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .key       (key),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .found_key (found_key),
        .position  (position),
        .count     (count),
        .full_res  (full_res)
    );

endmodule

// ----- dv/sorted_key_table_top_test.sv -----
module sorted_key_table_top_test;

    localparam int TABLE_DEPTH = 64;

    typedef struct packed {
        skt_pkg::status_t            st;
        logic [skt_pkg::FOUND_W-1:0] fkey;
        logic [skt_pkg::POS_W-1:0]   pos;
        logic [skt_pkg::COUNT_W-1:0] cnt;
        logic                        full;
    } table_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [skt_pkg::REQ_W-1:0]    req_type = '0;
    logic [skt_pkg::KEY_W-1:0]    key = '0;
    logic                         busy;
    logic                         done;
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::FOUND_W-1:0]  found_key;
    logic [skt_pkg::POS_W-1:0]    position;
    logic [skt_pkg::COUNT_W-1:0]  count;
    logic                         full_res;

    logic [skt_pkg::KEY_W-1:0] table_keys [TABLE_DEPTH];
    int                        table_fill = 0;
    table_result_t             expected_results [$];
    table_result_t             head_result;
    int                        error_count = 0;
    bit                        no_gaps = 1'b0;

    sorted_key_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .key       (key),
        .done      (done),
        .status    (status),
        .found_key (found_key),
        .position  (position),
        .count     (count),
        .full_res  (full_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("sorted_key_table_top regression: fail");
        $finish;
    end

    function automatic int find_key_index(logic [skt_pkg::KEY_W-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = table_fill - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_keys[mid] == k)
                return mid;
            if (table_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic table_result_t apply_request(skt_pkg::req_t req,
                                                    logic [skt_pkg::KEY_W-1:0] k);
        table_result_t res;
        int            i;
        int            idx;
        res = '0;
        res.st = skt_pkg::ST_OK;
        case (req)
            skt_pkg::REQ_INSERT:
            begin
                if (table_fill >= TABLE_DEPTH)
                    res.st = skt_pkg::ST_FULL;
                else
                begin
                    i = table_fill;
                    while (i > 0 && table_keys[i-1] > k)
                    begin
                        table_keys[i] = table_keys[i-1];
                        i--;
                    end
                    table_keys[i] = k;
                    table_fill++;
                    res.pos = i[skt_pkg::POS_W-1:0];
                end
            end
            skt_pkg::REQ_LOOKUP:
            begin
                idx = find_key_index(k);
                if (idx < 0)
                    res.st = skt_pkg::ST_NOT_FOUND;
                else
                begin
                    res.pos  = idx[skt_pkg::POS_W-1:0];
                    res.fkey = table_keys[idx];
                end
            end
            skt_pkg::REQ_DELETE:
            begin
                idx = find_key_index(k);
                if (idx < 0)
                    res.st = skt_pkg::ST_NOT_FOUND;
                else
                begin
                    res.pos = idx[skt_pkg::POS_W-1:0];
                    for (i = idx; i + 1 < table_fill; i++)
                        table_keys[i] = table_keys[i+1];
                    table_fill--;
                end
            end
            default:
                table_fill = 0;
        endcase
        res.cnt  = table_fill[skt_pkg::COUNT_W-1:0];
        res.full = (table_fill == TABLE_DEPTH);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request pending", found_key, 0);
            else
            begin
                head_result = expected_results.pop_front();
                if (status !== head_result.st)
                    report_mismatch("status", 32'(status), 32'(head_result.st));
                if (found_key !== head_result.fkey)
                    report_mismatch("found_key", found_key, head_result.fkey);
                if (position !== head_result.pos)
                    report_mismatch("position", 32'(position), 32'(head_result.pos));
                if (count !== head_result.cnt)
                    report_mismatch("count", 32'(count), 32'(head_result.cnt));
                if (full_res !== head_result.full)
                    report_mismatch("full_res", 32'(full_res), 32'(head_result.full));
            end
        end
    end

    task automatic send_request(skt_pkg::req_t req, logic [skt_pkg::KEY_W-1:0] k);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        key      <= k;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(apply_request(req, k));
    endtask

    function automatic logic [skt_pkg::KEY_W-1:0] pick_key(
        logic [skt_pkg::KEY_W-1:0] key_lim);
        int r;
        int j;
        r = $urandom_range(99);
        if (table_fill > 0 && r < 50)
        begin
            j = $urandom_range(table_fill - 1);
            return table_keys[j];
        end
        if (table_fill > 0 && r < 65)
        begin
            j = $urandom_range(table_fill - 1);
            return r[0] ? table_keys[j] + 1 : table_keys[j] - 1;
        end
        if (r < 68)
            return '0;
        if (r < 71)
            return '1;
        return (key_lim == '1) ? skt_pkg::KEY_W'($urandom)
                               : skt_pkg::KEY_W'($urandom_range(key_lim));
    endfunction

    task automatic run_traffic(int n, int w_ins, int w_look, int w_del, int w_clr,
                               logic [skt_pkg::KEY_W-1:0] key_lim);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 30 == 0)
                no_gaps = ($urandom_range(3) == 0);
            r = $urandom_range(w_ins + w_look + w_del + w_clr - 1);
            if (r < w_ins)
                send_request(skt_pkg::REQ_INSERT, pick_key(key_lim));
            else if (r < w_ins + w_look)
                send_request(skt_pkg::REQ_LOOKUP, pick_key(key_lim));
            else if (r < w_ins + w_look + w_del)
                send_request(skt_pkg::REQ_DELETE, pick_key(key_lim));
            else
                send_request(skt_pkg::REQ_CLEAR, skt_pkg::KEY_W'($urandom));
        end
    endtask

    task automatic test_directed;
        send_request(skt_pkg::REQ_LOOKUP, 32'h0000_0005);
        send_request(skt_pkg::REQ_DELETE, 32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(skt_pkg::REQ_LOOKUP, 32'h0000_0000);
        send_request(skt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_LOOKUP, 32'h7FFF_FFFF);
        send_request(skt_pkg::REQ_DELETE, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_DELETE, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_DELETE, 32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0005);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0005);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0005);
        send_request(skt_pkg::REQ_LOOKUP, 32'h0000_0005);
        send_request(skt_pkg::REQ_DELETE, 32'h0000_0005);
        send_request(skt_pkg::REQ_CLEAR,  32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_LOOKUP, 32'h0000_0005);
        send_request(skt_pkg::REQ_DELETE, 32'h0000_0005);
        send_request(skt_pkg::REQ_CLEAR,  32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'h5555_AAAA);
    endtask

    task automatic test_fill_and_drain;
        send_request(skt_pkg::REQ_CLEAR, skt_pkg::KEY_W'($urandom));
        while (table_fill < TABLE_DEPTH)
            send_request(skt_pkg::REQ_INSERT, pick_key('1));
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_LOOKUP, table_keys[TABLE_DEPTH-1]);
        send_request(skt_pkg::REQ_LOOKUP, table_keys[0]);
        run_traffic(8, 1, 1, 0, 0, '1);
        send_request(skt_pkg::REQ_DELETE, table_keys[0]);
        send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0001);
        send_request(skt_pkg::REQ_DELETE, table_keys[TABLE_DEPTH-1]);
        while (table_fill < TABLE_DEPTH)
            send_request(skt_pkg::REQ_INSERT, skt_pkg::KEY_W'($urandom));
        while (table_fill > 0)
            send_request(skt_pkg::REQ_DELETE, pick_key('1));
        send_request(skt_pkg::REQ_DELETE, skt_pkg::KEY_W'($urandom));
    endtask

    task automatic test_duplicate_keys;
        send_request(skt_pkg::REQ_CLEAR, skt_pkg::KEY_W'($urandom));
        run_traffic(250, 5, 3, 3, 0, 32'd7);
        run_traffic(50, 4, 3, 3, 1, 32'd3);
    endtask

    task automatic test_mixed_traffic;
        send_request(skt_pkg::REQ_CLEAR, skt_pkg::KEY_W'($urandom));
        run_traffic(400, 10, 6, 4, 1, '1);
    endtask

    task automatic test_request_noise;
        run_traffic(150, 1, 1, 1, 1, '1);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_drain();
        test_duplicate_keys();
        test_mixed_traffic();
        test_request_noise();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("sorted_key_table_top regression: pass");
        else
            $display("sorted_key_table_top regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/skt_pkg.sv
design/skt_dp.sv
design/skt_ctrl.sv
design/sorted_key_table_top.sv
dv/sorted_key_table_top_test.sv
